// ===== src/pfl_pkg.sv =====
// shared constants and types for the prime factor lister
`default_nettype none
package pfl_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DATA_W      = 32;
  localparam int N_W         = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam int MAX_RESULTS = 9;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int DIV_CNT_W   = $clog2(N_W);

  typedef logic [N_W-1:0] num_t;

  typedef struct packed {
    logic start;
    num_t dividend;
    num_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    num_t quotient;
    num_t remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/pfl_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module pfl_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pfl_pkg::div_req_t req,
  output pfl_pkg::div_rsp_t     rsp
);

  logic                       busy;
  logic                       done;
  logic [pfl_pkg::DIV_CNT_W-1:0] cnt;
  pfl_pkg::num_t              rem;
  pfl_pkg::num_t              quo;
  pfl_pkg::num_t              dvs;

  logic [pfl_pkg::N_W:0]      rem_sh;
  logic [pfl_pkg::N_W:0]      diff;
  logic                       fits;

  assign rem_sh = {rem, quo[pfl_pkg::N_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign fits   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == pfl_pkg::DIV_CNT_W'(pfl_pkg::N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[pfl_pkg::N_W-1:0] : rem_sh[pfl_pkg::N_W-1:0];
      quo <= {quo[pfl_pkg::N_W-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

// ===== src/prime_factor_lister_core.sv =====
// prime factor lister top level: trial division sequencer and stream ports
// Takes one unsigned number per request and returns its distinct prime divisors in
// ascending order, the final one marked by tlast; 0 and 1 give a single result with
// tuser set and factor 0. Work is trial division by 2 and then odd divisors up to the
// square root of the remaining value, all on one shared restoring divider. A number
// costs a division per divisor tried, plus the extra divisions that strip a repeated
// prime, so a prime near 2^32 needs roughly 32768 tries. tready is high only while no
// request is in work; a finished result waits in the output register and does not hold
// the next request off.
`default_nettype none
module prime_factor_lister_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // factor
  output logic             m_axis_tlast,
  output logic [0:0]       m_axis_tuser    // no_factors
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ZERO  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_PUSHP = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_LASTN = 3'd6;

  logic [2:0]                 state;
  pfl_pkg::num_t              n;
  pfl_pkg::num_t              d;
  pfl_pkg::num_t              pend;
  logic                       pend_valid;
  logic                       strip;
  logic [pfl_pkg::CNT_W-1:0]  count;

  pfl_pkg::div_req_t          div_req;
  pfl_pkg::div_rsp_t          div_rsp;

  pfl_pkg::num_t              d_next;
  logic                       out_free;
  logic                       out_load;
  logic                       accept;
  logic                       tail_n;

  assign d_next        = (d == pfl_pkg::N_W'(2)) ? pfl_pkg::N_W'(3) : d + pfl_pkg::N_W'(2);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign tail_n        = (n > pfl_pkg::N_W'(1)) &&
                         (count < pfl_pkg::CNT_W'(pfl_pkg::MAX_RESULTS));
  assign out_load      = out_free &&
                         ((state == S_ZERO) || (state == S_PUSHP) || (state == S_LASTN) ||
                          ((state == S_FIN) && !(tail_n && !pend_valid)));

  assign div_req.start    = (state == S_START);
  assign div_req.dividend = n;
  assign div_req.divisor  = d;

  pfl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pend_valid    <= 1'b0;
      strip         <= 1'b0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            n          <= s_axis_tdata[pfl_pkg::N_W-1:0];
            d          <= pfl_pkg::N_W'(2);
            pend_valid <= 1'b0;
            strip      <= 1'b0;
            count      <= '0;
            if (s_axis_tdata[pfl_pkg::N_W-1:0] < pfl_pkg::N_W'(2)) begin
              state <= S_ZERO;
            end else begin
              state <= S_START;
            end
          end
        end
        S_ZERO: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= '0;
            m_axis_tlast  <= 1'b1;
            m_axis_tuser  <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (strip) begin
              if (div_rsp.remainder == '0) begin
                n <= div_rsp.quotient;
              end else begin
                strip <= 1'b0;
                d     <= d_next;
              end
              state <= S_START;
            end else if ((d > div_rsp.quotient) ||
                         (count == pfl_pkg::CNT_W'(pfl_pkg::MAX_RESULTS))) begin
              state <= S_FIN;
            end else if (div_rsp.remainder == '0) begin
              n     <= div_rsp.quotient;
              strip <= 1'b1;
              count <= count + 1'b1;
              if (pend_valid) begin
                state <= S_PUSHP;
              end else begin
                pend       <= d;
                pend_valid <= 1'b1;
                state      <= S_START;
              end
            end else begin
              d     <= d_next;
              state <= S_START;
            end
          end
        end
        S_PUSHP: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= pfl_pkg::DATA_W'(pend);
            m_axis_tlast  <= 1'b0;
            m_axis_tuser  <= 1'b0;
            pend          <= d;
            state         <= S_START;
          end
        end
        S_FIN: begin
          if (tail_n) begin
            if (!pend_valid) begin
              state <= S_LASTN;
            end else if (out_free) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata  <= pfl_pkg::DATA_W'(pend);
              m_axis_tlast  <= 1'b0;
              m_axis_tuser  <= 1'b0;
              state         <= S_LASTN;
            end
          end else if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= pfl_pkg::DATA_W'(pend);
            m_axis_tlast  <= 1'b1;
            m_axis_tuser  <= 1'b0;
            state         <= S_IDLE;
          end
        end
        S_LASTN: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= pfl_pkg::DATA_W'(n);
            m_axis_tlast  <= 1'b1;
            m_axis_tuser  <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside the wait state");

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == 32'd0))
    else $error("no-factor result not alone");

  a_factor_ge2: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata >= 32'd2))
    else $error("listed factor below two");

  a_divisor_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (d >= pfl_pkg::N_W'(2)))
    else $error("trial divisor below two");
`endif

endmodule
`default_nettype wire
